// File: rtl/tqo_pkg.sv
// tqo_pkg: shared constants and types for the tilt quadrant orientation block.
// No dependencies; used by every module under rtl/.
`default_nettype none

package tqo_pkg;

   // Sample width default and its legal range
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SAMPLE_BITS_MIN = 8;
   localparam int SAMPLE_BITS_MAX = 32;

   // Threshold register
   localparam int MAG_BITS  = 15;
   localparam int THR_BITS  = 2 * MAG_BITS;
   localparam logic [MAG_BITS-1:0] MAG_RESET = 15'd3000;
   localparam logic [THR_BITS-1:0] THR_RESET = 30'd9000000;   // MAG_RESET squared

   // CSR map
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [0:0] CSR_IDX_MIN_MAG = 1'b0;

   // Quarter codes: which axis points down
   localparam logic [1:0] ROT_POS_Y = 2'd0;
   localparam logic [1:0] ROT_POS_X = 2'd1;
   localparam logic [1:0] ROT_NEG_Y = 2'd2;
   localparam logic [1:0] ROT_NEG_X = 2'd3;

   // Sign summary of one sample pair, carried alongside the squares
   typedef struct packed {
      logic x_pos;
      logic x_neg;
      logic y_pos;
      logic y_neg;
   } sign_type;

endpackage

`default_nettype wire

// File: rtl/tqo_csr.sv
// tqo_csr: APB-style register port holding min_magnitude and its registered square.
// Depends on tqo_pkg.
`default_nettype none

module tqo_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [tqo_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [tqo_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [tqo_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                      pready,
   output logic      [tqo_pkg::THR_BITS-1:0]         thr2
);

   logic [tqo_pkg::MAG_BITS-1:0] mag_ff, mag_in;
   logic [tqo_pkg::THR_BITS-1:0] thr2_ff, thr2_in;
   logic                         wr_hit;
   logic                         idx_ok;

   assign pready = 1'b1;
   assign idx_ok = (paddr[tqo_pkg::CSR_ADDR_BITS-1] == tqo_pkg::CSR_IDX_MIN_MAG);
   assign wr_hit = psel & penable & pwrite & pready & idx_ok;

   always_comb begin
      mag_in  = wr_hit ? pwdata[tqo_pkg::MAG_BITS-1:0] : mag_ff;
      thr2_in = tqo_pkg::THR_BITS'(mag_ff) * tqo_pkg::THR_BITS'(mag_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff  <= tqo_pkg::MAG_RESET;
         thr2_ff <= tqo_pkg::THR_RESET;
      end else begin
         mag_ff  <= mag_in;
         thr2_ff <= thr2_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (idx_ok) begin
         prdata[tqo_pkg::MAG_BITS-1:0] = mag_ff;
      end
   end

   assign thr2 = thr2_ff;

endmodule

`default_nettype wire

// File: rtl/tqo_square.sv
// tqo_square: request register and squaring stage (|x|^2, |y|^2, sign flags).
// Depends on tqo_pkg.
`default_nettype none

module tqo_square #(
   parameter int SAMPLE_BITS = tqo_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [SAMPLE_BITS-1:0]     req_accel_x,
   input  wire logic [SAMPLE_BITS-1:0]     req_accel_y,
   output logic                            req_stall,
   input  wire logic                       sq_take,
   output logic                            sq_valid,
   output logic      [2*SAMPLE_BITS-2:0]   ax2,
   output logic      [2*SAMPLE_BITS-2:0]   ay2,
   output tqo_pkg::sign_type               sign
);

   localparam int SQ_W = 2 * SAMPLE_BITS - 1;

   logic                      in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0]    x_ff, y_ff;
   logic                      sq_valid_ff, sq_valid_in;
   logic [SQ_W-1:0]           ax2_ff, ay2_ff, ax2_in, ay2_in;
   tqo_pkg::sign_type         sign_ff, sign_in;
   logic                      sq_en, in_en;
   logic [SAMPLE_BITS-1:0]    ax, ay;
   logic [2*SAMPLE_BITS-1:0]  ax_sq, ay_sq;

   // a stage loads when it is empty or its contents move on this cycle
   assign sq_en     = !sq_valid_ff || sq_take;
   assign in_en     = !in_valid_ff || sq_en;
   assign req_stall = !in_en;

   always_comb begin
      in_valid_in = in_en ? req_valid : in_valid_ff;
      sq_valid_in = sq_en ? in_valid_ff : sq_valid_ff;

      // magnitude of -2^(N-1) is 2^(N-1), which still fits N unsigned bits
      ax = x_ff[SAMPLE_BITS-1] ? (~x_ff + 1'b1) : x_ff;
      ay = y_ff[SAMPLE_BITS-1] ? (~y_ff + 1'b1) : y_ff;
      ax_sq  = ax * ax;
      ay_sq  = ay * ay;
      ax2_in = ax_sq[SQ_W-1:0];
      ay2_in = ay_sq[SQ_W-1:0];

      sign_in.x_neg = x_ff[SAMPLE_BITS-1];
      sign_in.y_neg = y_ff[SAMPLE_BITS-1];
      sign_in.x_pos = !x_ff[SAMPLE_BITS-1] && (x_ff != '0);
      sign_in.y_pos = !y_ff[SAMPLE_BITS-1] && (y_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         sq_valid_ff <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en && req_valid) begin
         x_ff <= req_accel_x;
         y_ff <= req_accel_y;
      end
      if (sq_en && in_valid_ff) begin
         ax2_ff  <= ax2_in;
         ay2_ff  <= ay2_in;
         sign_ff <= sign_in;
      end
   end

   assign sq_valid = sq_valid_ff;
   assign ax2      = ax2_ff;
   assign ay2      = ay2_ff;
   assign sign     = sign_ff;

endmodule

`default_nettype wire

// File: rtl/tqo_decide.sv
// tqo_decide: threshold and hysteresis decision, rotation state and result register.
// Depends on tqo_pkg.
`default_nettype none

module tqo_decide #(
   parameter int SAMPLE_BITS = tqo_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         sq_valid,
   input  wire logic [2*SAMPLE_BITS-2:0]     ax2,
   input  wire logic [2*SAMPLE_BITS-2:0]     ay2,
   input  wire tqo_pkg::sign_type            sign,
   input  wire logic [tqo_pkg::THR_BITS-1:0] thr2,
   output logic                              sq_take,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [1:0]                   rsp_rotation,
   output logic                              rsp_changed,
   output logic                              rsp_flat
);

   localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
   localparam int SUM_W = 2 * SAMPLE_BITS;
   localparam int CMP_W = (SUM_W > tqo_pkg::THR_BITS) ? SUM_W : tqo_pkg::THR_BITS;

   logic             out_en;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rot_ff, rot_in;
   logic [1:0]       rsp_rotation_ff, rsp_rotation_in;
   logic             rsp_changed_ff, rsp_changed_in;
   logic             rsp_flat_ff, rsp_flat_in;

   logic [CMP_W-1:0] mag2, thr2_ext;
   logic             flat;
   logic [SQ_W-1:0]  up2, uq2;
   logic             p_pos;
   logic [SUM_W-1:0] up2_x3;
   logic             keep;
   logic [1:0]       nearest;
   logic [1:0]       next_rot;

   assign out_en  = !rsp_valid_ff || !rsp_stall;
   assign sq_take = sq_valid && out_en;

   always_comb begin
      mag2     = CMP_W'(ax2) + CMP_W'(ay2);
      thr2_ext = CMP_W'(thr2);
      flat     = mag2 < thr2_ext;

      // project onto the current quarter's frame: p along, q across
      case (rot_ff)
         tqo_pkg::ROT_POS_Y: begin
            up2 = ay2; uq2 = ax2; p_pos = sign.y_pos;
         end
         tqo_pkg::ROT_POS_X: begin
            up2 = ax2; uq2 = ay2; p_pos = sign.x_pos;
         end
         tqo_pkg::ROT_NEG_Y: begin
            up2 = ay2; uq2 = ax2; p_pos = sign.y_neg;
         end
         default: begin
            up2 = ax2; uq2 = ay2; p_pos = sign.x_neg;
         end
      endcase

      // within 60 degrees: q^2 <= 3 p^2
      up2_x3 = SUM_W'(up2) + {up2, 1'b0};
      keep   = p_pos && (SUM_W'(uq2) <= up2_x3);

      if (!(sign.x_pos || sign.x_neg || sign.y_pos || sign.y_neg)) begin
         nearest = tqo_pkg::ROT_POS_Y;
      end else if (ay2 > ax2) begin
         nearest = sign.y_pos ? tqo_pkg::ROT_POS_Y : tqo_pkg::ROT_NEG_Y;
      end else if (ax2 > ay2) begin
         nearest = sign.x_pos ? tqo_pkg::ROT_POS_X : tqo_pkg::ROT_NEG_X;
      end else if (sign.x_pos) begin
         // diagonal tie goes to the higher clockwise angle
         nearest = sign.y_pos ? tqo_pkg::ROT_POS_X : tqo_pkg::ROT_NEG_Y;
      end else begin
         nearest = sign.y_neg ? tqo_pkg::ROT_NEG_X : tqo_pkg::ROT_POS_Y;
      end

      next_rot = (flat || keep) ? rot_ff : nearest;

      rot_in          = sq_take ? next_rot : rot_ff;
      rsp_valid_in    = out_en ? sq_valid : rsp_valid_ff;
      rsp_rotation_in = next_rot;
      rsp_changed_in  = next_rot != rot_ff;
      rsp_flat_in     = flat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff       <= tqo_pkg::ROT_POS_Y;
         rsp_valid_ff <= 1'b0;
      end else begin
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_take) begin
         rsp_rotation_ff <= rsp_rotation_in;
         rsp_changed_ff  <= rsp_changed_in;
         rsp_flat_ff     <= rsp_flat_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rotation = rsp_rotation_ff;
   assign rsp_changed  = rsp_changed_ff;
   assign rsp_flat     = rsp_flat_ff;

endmodule

`default_nettype wire

// File: rtl/tilt_quadrant_orientation.sv
// Tilt quadrant orientation: one signed (x, y) accelerometer request in, one result out
// (quarter-turn rotation, changed flag, flat flag) with 60-degree hysteresis around the
// current quarter and a programmable minimum magnitude. Throughput is one request per
// clock unless rsp_stall holds the pipeline; a request passes the request register, the
// squaring register and the result register before rsp_valid rises, the first loaded at
// the accepting edge. The rotation state sits beside the result register, so each
// request sees the rotation left by the one before it. min_magnitude lives at byte address
// 0 and resets to 3000; its square is registered, so write it only while the block is idle.
// Depends on tqo_pkg, tqo_csr, tqo_square and tqo_decide.
`default_nettype none

module tilt_quadrant_orientation #(
   parameter int SAMPLE_BITS = tqo_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [SAMPLE_BITS-1:0]            req_accel_x,
   input  wire logic [SAMPLE_BITS-1:0]            req_accel_y,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [1:0]                        rsp_rotation,
   output logic                                   rsp_changed,
   output logic                                   rsp_flat,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [tqo_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [tqo_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [tqo_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                   pready
);

   logic                         sq_take;
   logic                         sq_valid;
   logic [2*SAMPLE_BITS-2:0]     ax2, ay2;
   tqo_pkg::sign_type            sign;
   logic [tqo_pkg::THR_BITS-1:0] thr2;

   tqo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .thr2    (thr2)
   );

   tqo_square #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_square (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_stall   (req_stall),
      .sq_take     (sq_take),
      .sq_valid    (sq_valid),
      .ax2         (ax2),
      .ay2         (ay2),
      .sign        (sign)
   );

   tqo_decide #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_decide (
      .clock        (clock),
      .reset        (reset),
      .sq_valid     (sq_valid),
      .ax2          (ax2),
      .ay2          (ay2),
      .sign         (sign),
      .thr2         (thr2),
      .sq_take      (sq_take),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_rotation (rsp_rotation),
      .rsp_changed  (rsp_changed),
      .rsp_flat     (rsp_flat)
   );

endmodule

`default_nettype wire

// File: dv/tb.sv
// tb: self-checking bench for tilt_quadrant_orientation (tqo_pkg, rtl/ top level).
// A table of directed samples, then random samples under three idle/stall mixes and
// several min_magnitude settings, scored against table expectations or an in-bench predictor.
`timescale 1ns / 100ps

module tb;

   localparam int SW            = tqo_pkg::SAMPLE_BITS_DEF;
   localparam int RSP_LATENCY   = 2;
   localparam int WATCHDOG      = 2000;
   localparam int CSR_IDX_SPARE = 1;      // unmapped register slot, writes are dropped
   localparam int PHASE_ITEMS   = 100;

   typedef struct packed {
      logic [1:0] rotation;
      logic       changed;
      logic       flat;
   } orient_type;

   typedef struct {
      bit          is_cfg;
      logic [31:0] value;
      logic [SW-1:0] x;
      logic [SW-1:0] y;
      bit          typed;
      orient_type  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [SW-1:0] req_accel_x = '0;
   logic [SW-1:0] req_accel_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_rotation;
   logic rsp_changed;
   logic rsp_flat;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [tqo_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [tqo_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [tqo_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   // predictor state
   logic [1:0]                   quarter_now = tqo_pkg::ROT_POS_Y;
   logic [tqo_pkg::MAG_BITS-1:0] mag_now     = tqo_pkg::MAG_RESET;

   orient_type   expected_orient_q[$];
   stim_row_type directed_rows[$];

   int errors    = 0;
   int n_samples = 0;
   int n_results = 0;
   int n_flat    = 0;
   int n_turns   = 0;
   int n_cfg     = 0;
   int quiet     = 0;
   int idle_pct  = 0;
   int stall_pct = 0;

   tilt_quadrant_orientation dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_rotation(rsp_rotation),
      .rsp_changed (rsp_changed),
      .rsp_flat    (rsp_flat),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #5 clock = ~clock;

   // Orientation for one accepted sample; advances the predicted quarter.
   function automatic orient_type orient_step(input logic [SW-1:0] sx,
                                              input logic [SW-1:0] sy);
      longint  x, y, ax, ay, p, q;
      logic [1:0] old_q, new_q;
      orient_type r;
      x = longint'($signed(sx));
      y = longint'($signed(sy));
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      old_q = quarter_now;
      if (ax * ax + ay * ay < longint'(mag_now) * longint'(mag_now)) begin
         r.rotation = old_q;
         r.changed  = 1'b0;
         r.flat     = 1'b1;
         return r;
      end
      case (old_q)
         tqo_pkg::ROT_POS_Y: begin p = y;  q = x;  end
         tqo_pkg::ROT_POS_X: begin p = x;  q = -y; end
         tqo_pkg::ROT_NEG_Y: begin p = -y; q = x;  end
         default:            begin p = -x; q = y;  end
      endcase
      new_q = old_q;
      // hold the quarter inside +/-60 degrees of its axis (q^2 <= 3 p^2)
      if (!(p > 0 && q * q <= 3 * p * p)) begin
         if (ax == 0 && ay == 0)
            new_q = tqo_pkg::ROT_POS_Y;
         else if (ay > ax)
            new_q = (y > 0) ? tqo_pkg::ROT_POS_Y : tqo_pkg::ROT_NEG_Y;
         else if (ax > ay)
            new_q = (x > 0) ? tqo_pkg::ROT_POS_X : tqo_pkg::ROT_NEG_X;
         else if (x > 0)       // diagonal: higher clockwise angle wins
            new_q = (y > 0) ? tqo_pkg::ROT_POS_X : tqo_pkg::ROT_NEG_Y;
         else
            new_q = (y < 0) ? tqo_pkg::ROT_NEG_X : tqo_pkg::ROT_POS_Y;
      end
      quarter_now = new_q;
      r.rotation  = new_q;
      r.changed   = (new_q != old_q);
      r.flat      = 1'b0;
      return r;
   endfunction

   // Response scoreboard, stall generator and watchdog
   always @(posedge clock) begin
      orient_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_orient_q.size() == 0) begin
            errors++;
            $display("%0t: result with no request pending: rotation=%0d changed=%0b flat=%0b",
                     $time, rsp_rotation, rsp_changed, rsp_flat);
         end else begin
            want = expected_orient_q.pop_front();
            n_results++;
            if (want.flat) n_flat++;
            if (want.changed) n_turns++;
            if (rsp_rotation !== want.rotation) begin
               errors++;
               $display("%0t: rotation expected %0d got %0d", $time, want.rotation,
                        rsp_rotation);
            end
            if (rsp_changed !== want.changed) begin
               errors++;
               $display("%0t: changed expected %0b got %0b", $time, want.changed, rsp_changed);
            end
            if (rsp_flat !== want.flat) begin
               errors++;
               $display("%0t: flat expected %0b got %0b", $time, want.flat, rsp_flat);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet = 0;
      else
         quiet++;
      if (quiet >= WATCHDOG) begin
         $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic drain_results();
      while (expected_orient_q.size() != 0)
         @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input int idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= tqo_pkg::CSR_ADDR_BITS'(idx * 4);
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Write a register while idle, then read back min_magnitude.
   task automatic write_csr_checked(input int idx, input logic [31:0] value);
      logic [31:0] rd;
      req_valid <= 1'b0;
      drain_results();
      csr_access(1'b1, idx, value, rd);
      if (idx == int'(tqo_pkg::CSR_IDX_MIN_MAG))
         mag_now = value[tqo_pkg::MAG_BITS-1:0];
      n_cfg++;
      csr_access(1'b0, int'(tqo_pkg::CSR_IDX_MIN_MAG), '0, rd);
      if (rd !== {{(tqo_pkg::CSR_DATA_BITS-tqo_pkg::MAG_BITS){1'b0}}, mag_now}) begin
         errors++;
         $display("%0t: min_magnitude readback expected %0d got %0d", $time, mag_now, rd);
      end
   endtask

   task automatic send_sample(input logic [SW-1:0] x, input logic [SW-1:0] y,
                              input bit typed, input orient_type want);
      orient_type pred;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= x;
      req_accel_y <= y;
      do @(posedge clock); while (req_stall !== 1'b0);
      pred = orient_step(x, y);
      expected_orient_q.push_back(typed ? want : pred);
      n_samples++;
   endtask

   task automatic add_sample(input int x, input int y, input int rot = -1,
                             input bit ch = 1'b0, input bit fl = 1'b0);
      stim_row_type row;
      row.is_cfg = 1'b0;
      row.value  = '0;
      row.x      = SW'(x);
      row.y      = SW'(y);
      row.typed  = (rot >= 0);
      row.want   = '{rotation: 2'(rot), changed: ch, flat: fl};
      directed_rows.push_back(row);
   endtask

   task automatic add_threshold(input int value);
      stim_row_type row;
      row = '{is_cfg: 1'b1, value: value, x: '0, y: '0, typed: 1'b0, want: '0};
      directed_rows.push_back(row);
   endtask

   // Random sample, biased toward the hysteresis edge of the predicted quarter,
   // diagonals, extremes and the magnitude threshold.
   task automatic make_sample(output logic [SW-1:0] sx, output logic [SW-1:0] sy);
      int kind, p, q, a, m, x, y;
      int edges[6];
      edges = '{-32768, -32767, -1, 0, 1, 32767};
      kind = $urandom_range(99);
      if (kind < 15) begin
         x = int'($urandom_range(65535)) - 32768;
         y = int'($urandom_range(65535)) - 32768;
      end else if (kind < 25) begin
         x = edges[$urandom_range(5)];
         y = edges[$urandom_range(5)];
      end else if (kind < 65) begin
         p = $urandom_range(18000, 1);
         q = int'($sqrt(3.0 * p * p)) + int'($urandom_range(4)) - 2;
         if ($urandom_range(1)) q = -q;
         if ($urandom_range(7) == 0) p = -p;
         case (quarter_now)
            tqo_pkg::ROT_POS_Y: begin x = q;  y = p;  end
            tqo_pkg::ROT_POS_X: begin x = p;  y = -q; end
            tqo_pkg::ROT_NEG_Y: begin x = q;  y = -p; end
            default:            begin x = -p; y = q;  end
         endcase
      end else if (kind < 80) begin
         a = $urandom_range(32768);
         x = $urandom_range(1) ? a : -a;
         y = $urandom_range(1) ? a : -a;
      end else begin
         m = int'(mag_now) + int'($urandom_range(2)) - 1;
         a = int'($urandom_range(8)) - 4;
         if ($urandom_range(1)) m = -m;
         if ($urandom_range(1)) begin x = m; y = a; end
         else begin x = a; y = m; end
      end
      x = (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
      y = (y > 32767) ? 32767 : (y < -32768) ? -32768 : y;
      sx = SW'(x);
      sy = SW'(y);
   endtask

   initial begin
      logic [SW-1:0] rx, ry;
      logic [31:0] plan[6];
      int ph, i;

      // Directed table, threshold 3000 out of reset, quarter starts at +y.
      add_sample(0, 0, tqo_pkg::ROT_POS_Y, 0, 1);
      add_sample(2999, 0, tqo_pkg::ROT_POS_Y, 0, 1);             // just under threshold
      add_sample(0, 32767, tqo_pkg::ROT_POS_Y, 0, 0);
      add_sample(-32768, 0, tqo_pkg::ROT_NEG_X, 1, 0);
      add_sample(3000, 0, tqo_pkg::ROT_POS_X, 1, 0);             // exactly on threshold
      add_sample(0, -32768, tqo_pkg::ROT_NEG_Y, 1, 0);
      add_sample(0, -3000, tqo_pkg::ROT_NEG_Y, 0, 0);
      add_sample(20000, 20000, tqo_pkg::ROT_POS_X, 1, 0);        // diagonal ties
      add_sample(-20000, 20000, tqo_pkg::ROT_POS_Y, 1, 0);
      add_sample(20000, -20000, tqo_pkg::ROT_NEG_Y, 1, 0);
      add_sample(-20000, -20000, tqo_pkg::ROT_NEG_Y, 0, 0);      // diagonal held
      add_sample(32767, -32768, tqo_pkg::ROT_NEG_Y, 0, 0);
      add_sample(32767, 0, tqo_pkg::ROT_POS_X, 1, 0);
      add_sample(-32768, -32768, tqo_pkg::ROT_NEG_X, 1, 0);
      add_sample(-10000, 17320);                        // 60 degree edge, inside
      add_sample(-10000, 17321);                        // just outside
      add_sample(17320, 10000);
      add_sample(17321, 10000);
      add_sample(32767, 32767);
      add_threshold(0);
      add_sample(0, 0, tqo_pkg::ROT_POS_Y, 1, 0);       // zero vector counts as +y
      add_sample(1, -1);
      add_threshold(32767);
      add_sample(32766, 0, tqo_pkg::ROT_NEG_Y, 0, 1);
      add_sample(32767, 0, tqo_pkg::ROT_POS_X, 1, 0);
      add_sample(-32768, 32767);

      idle_pct  = 10;
      stall_pct = 46;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_cfg)
            write_csr_checked(int'(tqo_pkg::CSR_IDX_MIN_MAG), directed_rows[k].value);
         else
            send_sample(directed_rows[k].x, directed_rows[k].y, directed_rows[k].typed,
                        directed_rows[k].want);
      end

      // Random part: upper bits in one write must be dropped
      plan = '{32'd1500, 32'hFFFF_8000, 32'd32767, 32'($urandom_range(32767)),
               32'd100, 32'd3000};
      for (ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0:       begin idle_pct = 10; stall_pct = 46; end
            1:       begin idle_pct = 46; stall_pct = 10; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
         endcase
         if (ph == 3)
            write_csr_checked(CSR_IDX_SPARE, 32'h0000_1234);
         write_csr_checked(int'(tqo_pkg::CSR_IDX_MIN_MAG), plan[ph]);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(39) == 0) begin
               req_valid <= 1'b0;
               drain_results();
            end
            make_sample(rx, ry);
            send_sample(rx, ry, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      drain_results();
      repeat (8) @(posedge clock);

      $display("Run: %0d samples, %0d results scored (%0d flat, %0d rotation changes).",
               n_samples, n_results, n_flat, n_turns);
      $display("     %0d register writes across threshold settings and three idle/stall mixes.",
               n_cfg);
      if (errors == 0 && expected_orient_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tqo_pkg.sv
rtl/tqo_csr.sv
rtl/tqo_square.sv
rtl/tqo_decide.sv
rtl/tilt_quadrant_orientation.sv
dv/tb.sv
